/* src/rece_pkg.sv */
// Shared types and constants of the routing edge congestion ledger.
// Used by the shared update unit and the top level; depends on nothing.
`default_nettype none

package rece_pkg;

   // Operation requested on one edge
   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_SWEEP  = 2'd3
   } mode_type;

   // Result status
   typedef enum logic [1:0] {
      ERR_OK   = 2'd0,
      ERR_EDGE = 2'd1,
      ERR_SAT  = 2'd2
   } error_type;

   // Operations of the shared update unit
   typedef enum logic [1:0] {
      ALU_NONE = 2'd0,
      ALU_INC  = 2'd1,
      ALU_DEC  = 2'd2,
      ALU_BUMP = 2'd3
   } alu_op_type;

   // Register indexes of the control port
   typedef enum logic [1:0] {
      CSR_COLUMNS = 2'd0,
      CSR_ROWS    = 2'd1,
      CSR_HCAP    = 2'd2,
      CSR_VCAP    = 2'd3
   } csr_index_type;

   localparam logic [15:0] HISTORY_MAX   = 16'hFFFF;
   localparam logic [15:0] HISTORY_RESET = 16'd1;
   localparam logic [6:0]  GRID_RESET    = 7'd64;
   localparam logic [15:0] CAP_RESET     = 16'd1;

endpackage : rece_pkg

`default_nettype wire

/* src/routing_edge_congestion_ledger_core.sv */
// Top level of the routing edge congestion ledger: control registers, sequencer,
// edge tables in two RAMs. Depends on rece_pkg, rece_ram and rece_alu.
// Add, remove, query: LOOKUP reads tables, APPLY waits out a stall, registers the word.
// Sweep: each point read, its horizontal and vertical edges bumped in the update unit; then LOOKUP, APPLY.
// Reset: every table address cleared in turn, req_stall high meanwhile.
// Reset sets the control registers to their reset values and clears the overflow total at once.
`default_nettype none

module routing_edge_congestion_ledger_core #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 64,
   parameter int DEMAND_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [5:0]  req_from_x,
   input  wire logic [5:0]  req_from_y,
   input  wire logic [5:0]  req_to_x,
   input  wire logic [5:0]  req_to_y,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_edge_demand,
   output logic [15:0]      rsp_edge_capacity,
   output logic [15:0]      rsp_edge_history,
   output logic [15:0]      rsp_edge_excess,
   output logic [31:0]      rsp_overflow_sum,
   output logic [1:0]       rsp_error,
   // control register port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import rece_pkg::*;

   localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_COLUMNS + 1);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int XW    = $clog2(MAX_COLUMNS);
   localparam int YW    = $clog2(MAX_ROWS);
   localparam int EW    = (DEMAND_BITS > 16) ? DEMAND_BITS : 16;
   localparam int MW    = DEMAND_BITS + 16;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SW_RD,
      ST_SW_H,
      ST_SW_V,
      ST_LOOKUP,
      ST_APPLY
   } state_type;

   // control registers
   logic [6:0]  grid_columns_ff;
   logic [6:0]  grid_rows_ff;
   logic [15:0] hcap_ff;
   logic [15:0] vcap_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= GRID_RESET;
         grid_rows_ff    <= GRID_RESET;
         hcap_ff         <= CAP_RESET;
         vcap_ff         <= CAP_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_COLUMNS: grid_columns_ff <= csr_wdata[6:0];
            CSR_ROWS:    grid_rows_ff    <= csr_wdata[6:0];
            CSR_HCAP:    hcap_ff         <= csr_wdata;
            CSR_VCAP:    vcap_ff         <= csr_wdata;
            default:     hcap_ff         <= hcap_ff;
         endcase
      end
   end

   // clamped grid size
   logic [CW-1:0] cols_w;
   logic [RW-1:0] rows_w;

   always_comb begin
      if (grid_columns_ff < 7'd2) cols_w = CW'(2);
      else if (32'(grid_columns_ff) > MAX_COLUMNS) cols_w = CW'(MAX_COLUMNS);
      else cols_w = CW'(grid_columns_ff);
      if (grid_rows_ff < 7'd2) rows_w = RW'(2);
      else if (32'(grid_rows_ff) > MAX_ROWS) rows_w = RW'(MAX_ROWS);
      else rows_w = RW'(grid_rows_ff);
   end

   // sequencer registers
   state_type     state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [XW-1:0] sx_ff, sx_in;
   logic [YW-1:0] sy_ff, sy_in;
   mode_type      mode_ff, mode_in;
   logic [5:0]    fx_ff, fx_in, fy_ff, fy_in, tx_ff, tx_in, ty_ff, ty_in;
   logic [31:0]   sum_ff, sum_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   dem_out_ff, dem_out_in;
   logic [15:0]   cap_out_ff, cap_out_in;
   logic [15:0]   his_out_ff, his_out_in;
   logic [15:0]   ex_out_ff, ex_out_in;
   logic [31:0]   tot_out_ff, tot_out_in;
   error_type     err_out_ff, err_out_in;

   // edge decode from the captured word
   logic          in_grid, horiz_adj, vert_adj, legal;
   logic [5:0]    min_x, min_y;
   logic [AW-1:0] edge_addr, sweep_addr;

   always_comb begin
      in_grid = (32'(fx_ff) < 32'(cols_w)) && (32'(tx_ff) < 32'(cols_w)) &&
                (32'(fy_ff) < 32'(rows_w)) && (32'(ty_ff) < 32'(rows_w));
      horiz_adj = (fy_ff == ty_ff) &&
                  ((7'(fx_ff) + 7'd1 == 7'(tx_ff)) || (7'(tx_ff) + 7'd1 == 7'(fx_ff)));
      vert_adj  = (fx_ff == tx_ff) &&
                  ((7'(fy_ff) + 7'd1 == 7'(ty_ff)) || (7'(ty_ff) + 7'd1 == 7'(fy_ff)));
      legal = in_grid && (horiz_adj || vert_adj);
      min_x = (fx_ff < tx_ff) ? fx_ff : tx_ff;
      min_y = (fy_ff < ty_ff) ? fy_ff : ty_ff;
      if (horiz_adj) edge_addr = AW'(int'(min_x) * MAX_ROWS + int'(fy_ff));
      else edge_addr = AW'(int'(fx_ff) * MAX_ROWS + int'(min_y));
      sweep_addr = AW'(int'(sx_ff) * MAX_ROWS + int'(sy_ff));
   end

   // edge tables: {history, demand}
   logic          h_wr_en, v_wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [MW-1:0] wr_data, h_rd_data, v_rd_data;

   rece_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_hram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (h_rd_data)
   );

   rece_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_vram (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (v_rd_data)
   );

   // shared update unit, fed from the table that is selected
   alu_op_type             alu_op;
   logic                   sel_vert;
   logic [MW-1:0]          cur_entry;
   logic [15:0]            cur_cap;
   logic [DEMAND_BITS-1:0] alu_demand;
   logic [15:0]            alu_history;
   logic                   alu_sat;
   logic [EW-1:0]          alu_old_ex, alu_new_ex;
   logic [EW-1:0]          dem_ext;

   assign sel_vert  = (state_ff == ST_SW_V) || (state_ff == ST_APPLY && !horiz_adj);
   assign cur_entry = sel_vert ? v_rd_data : h_rd_data;
   assign cur_cap   = sel_vert ? vcap_ff : hcap_ff;
   assign dem_ext   = EW'(alu_demand);

   rece_alu #(.DEMAND_BITS(DEMAND_BITS)) u_alu (
      .alu_op      (alu_op),
      .cur_demand  (cur_entry[DEMAND_BITS-1:0]),
      .cur_history (cur_entry[MW-1:DEMAND_BITS]),
      .capacity    (cur_cap),
      .new_demand  (alu_demand),
      .new_history (alu_history),
      .saturated   (alu_sat),
      .old_excess  (alu_old_ex),
      .new_excess  (alu_new_ex)
   );

   logic out_free, demand_op;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign demand_op = legal && (mode_ff == MODE_ADD || mode_ff == MODE_REMOVE);

   // unit opcode and table write port
   always_comb begin
      alu_op  = ALU_NONE;
      h_wr_en = 1'b0;
      v_wr_en = 1'b0;
      wr_addr = edge_addr;
      rd_addr = edge_addr;
      wr_data = {alu_history, alu_demand};
      case (state_ff)
         ST_CLEAR: begin
            h_wr_en = 1'b1;
            v_wr_en = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = {HISTORY_RESET, DEMAND_BITS'(0)};
         end
         ST_SW_RD: begin
            rd_addr = sweep_addr;
         end
         ST_SW_H: begin
            rd_addr = sweep_addr;
            wr_addr = sweep_addr;
            if (32'(sx_ff) + 32'd1 < 32'(cols_w)) alu_op = ALU_BUMP;
            h_wr_en = 1'b1;
         end
         ST_SW_V: begin
            rd_addr = sweep_addr;
            wr_addr = sweep_addr;
            if (32'(sy_ff) + 32'd1 < 32'(rows_w)) alu_op = ALU_BUMP;
            v_wr_en = 1'b1;
         end
         ST_APPLY: begin
            if (legal && mode_ff == MODE_ADD) alu_op = ALU_INC;
            else if (legal && mode_ff == MODE_REMOVE) alu_op = ALU_DEC;
            if (out_free && demand_op && !alu_sat) begin
               h_wr_en = horiz_adj;
               v_wr_en = !horiz_adj;
            end
         end
         default: begin
            alu_op = ALU_NONE;
         end
      endcase
   end

   // overflow total with saturation and floor
   logic [32:0] sum_up;
   logic [31:0] sum_dn, sum_adj;

   always_comb begin
      sum_up = {1'b0, sum_ff} + 33'(32'(alu_new_ex - alu_old_ex));
      sum_dn = 32'(alu_old_ex - alu_new_ex);
      if (alu_new_ex >= alu_old_ex) sum_adj = sum_up[32] ? 32'hFFFF_FFFF : sum_up[31:0];
      else sum_adj = (sum_ff > sum_dn) ? sum_ff - sum_dn : 32'd0;
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      mode_in      = mode_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      sum_in       = sum_ff;
      dem_out_in   = dem_out_ff;
      cap_out_in   = cap_out_ff;
      his_out_in   = his_out_ff;
      ex_out_in    = ex_out_ff;
      tot_out_in   = tot_out_ff;
      err_out_in   = err_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = mode_type'(req_mode);
               fx_in   = req_from_x;
               fy_in   = req_from_y;
               tx_in   = req_to_x;
               ty_in   = req_to_y;
               sx_in   = '0;
               sy_in   = '0;
               state_in = (req_mode == MODE_SWEEP) ? ST_SW_RD : ST_LOOKUP;
            end
         end
         ST_SW_RD: state_in = ST_SW_H;
         ST_SW_H:  state_in = ST_SW_V;
         ST_SW_V: begin
            state_in = ST_SW_RD;
            if (32'(sy_ff) + 32'd1 == 32'(rows_w)) begin
               sy_in = '0;
               if (32'(sx_ff) + 32'd1 == 32'(cols_w)) state_in = ST_LOOKUP;
               else sx_in = sx_ff + XW'(1);
            end else begin
               sy_in = sy_ff + YW'(1);
            end
         end
         ST_LOOKUP: state_in = ST_APPLY;
         ST_APPLY: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (demand_op) sum_in = sum_adj;
               if (legal) begin
                  dem_out_in = dem_ext[15:0];
                  cap_out_in = cur_cap;
                  his_out_in = alu_history;
                  ex_out_in  = alu_new_ex[15:0];
                  err_out_in = alu_sat ? ERR_SAT : ERR_OK;
               end else begin
                  dem_out_in = '0;
                  cap_out_in = '0;
                  his_out_in = '0;
                  ex_out_in  = '0;
                  err_out_in = ERR_EDGE;
               end
               tot_out_in = demand_op ? sum_adj : sum_ff;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         mode_ff      <= mode_in;
         fx_ff        <= fx_in;
         fy_ff        <= fy_in;
         tx_ff        <= tx_in;
         ty_ff        <= ty_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         dem_out_ff   <= dem_out_in;
         cap_out_ff   <= cap_out_in;
         his_out_ff   <= his_out_in;
         ex_out_ff    <= ex_out_in;
         tot_out_ff   <= tot_out_in;
         err_out_ff   <= err_out_in;
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_edge_demand    = dem_out_ff;
   assign rsp_edge_capacity  = cap_out_ff;
   assign rsp_edge_history   = his_out_ff;
   assign rsp_edge_excess    = ex_out_ff;
   assign rsp_overflow_sum   = tot_out_ff;
   assign rsp_error          = err_out_ff;

   // tables are never written while waiting for a word
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(h_wr_en || v_wr_en))
      else $error("table write while idle");

   // only the clearing pass writes both tables at once
   a_one_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |-> !(h_wr_en && v_wr_en))
      else $error("both tables written outside clearing pass");

   // overflow total moves only when an edge update completes
   a_sum_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_APPLY) |=> $stable(sum_ff))
      else $error("overflow total changed outside update");

   // a response appears only out of the update step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_APPLY))
      else $error("response without update step");

endmodule : routing_edge_congestion_ledger_core

`default_nettype wire

/* src/rece_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rece_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : rece_ram

`default_nettype wire

/* src/rece_alu.sv */
// Shared update unit: one demand step or history bump on a table entry,
// plus excess before and after. Depends on rece_pkg.
`default_nettype none

module rece_alu #(
   parameter int DEMAND_BITS = 16
) (
   input  wire logic [1:0]             alu_op,
   input  wire logic [DEMAND_BITS-1:0] cur_demand,
   input  wire logic [15:0]            cur_history,
   input  wire logic [15:0]            capacity,
   output logic      [DEMAND_BITS-1:0] new_demand,
   output logic      [15:0]            new_history,
   output logic                        saturated,
   output logic [((DEMAND_BITS > 16) ? DEMAND_BITS : 16)-1:0] old_excess,
   output logic [((DEMAND_BITS > 16) ? DEMAND_BITS : 16)-1:0] new_excess
);
   import rece_pkg::*;

   localparam int EW = (DEMAND_BITS > 16) ? DEMAND_BITS : 16;

   logic [EW-1:0] cur_ext;
   logic [EW-1:0] new_ext;
   logic [EW-1:0] cap_ext;

   assign cur_ext = EW'(cur_demand);
   assign new_ext = EW'(new_demand);
   assign cap_ext = EW'(capacity);

   // demand step / history bump
   always_comb begin
      new_demand  = cur_demand;
      new_history = cur_history;
      saturated   = 1'b0;
      case (alu_op_type'(alu_op))
         ALU_INC: begin
            if (cur_demand == {DEMAND_BITS{1'b1}}) saturated = 1'b1;
            else new_demand = cur_demand + DEMAND_BITS'(1);
         end
         ALU_DEC: begin
            if (cur_demand == '0) saturated = 1'b1;
            else new_demand = cur_demand - DEMAND_BITS'(1);
         end
         ALU_BUMP: begin
            if (cur_ext > cap_ext && cur_history != HISTORY_MAX) begin
               new_history = cur_history + 16'd1;
            end
         end
         default: begin
            new_demand = cur_demand;
         end
      endcase
   end

   // demand above capacity
   assign old_excess = (cur_ext > cap_ext) ? cur_ext - cap_ext : '0;
   assign new_excess = (new_ext > cap_ext) ? new_ext - cap_ext : '0;

endmodule : rece_alu

`default_nettype wire

/* verif/routing_edge_congestion_ledger_tb.sv */
// Testbench for routing_edge_congestion_ledger_core: edge add/remove/query/sweep
// words checked against an in-bench model of the usage table. Depends on rece_pkg.
`default_nettype none

module testbench;
   import rece_pkg::*;

   localparam int          GRID_MAX   = 64;
   localparam logic [15:0] DEMAND_TOP = 16'hFFFF;

   typedef struct packed {
      mode_type   mode;
      logic [5:0] from_x;
      logic [5:0] from_y;
      logic [5:0] to_x;
      logic [5:0] to_y;
   } ledger_request_type;

   typedef struct packed {
      logic [15:0] demand;
      logic [15:0] capacity;
      logic [15:0] history;
      logic [15:0] excess;
      logic [31:0] overflow;
      error_type   err;
   } ledger_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode = '0;
   logic [5:0]  req_from_x = '0;
   logic [5:0]  req_from_y = '0;
   logic [5:0]  req_to_x = '0;
   logic [5:0]  req_to_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_edge_demand;
   logic [15:0] rsp_edge_capacity;
   logic [15:0] rsp_edge_history;
   logic [15:0] rsp_edge_excess;
   logic [31:0] rsp_overflow_sum;
   logic [1:0]  rsp_error;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   routing_edge_congestion_ledger_core dut (.*);

   always #5 clock = ~clock;

   // Model of the usage table and its registers
   logic [15:0] horiz_demand  [0:4095];
   logic [15:0] horiz_history [0:4095];
   logic [15:0] vert_demand   [0:4095];
   logic [15:0] vert_history  [0:4095];
   logic [31:0] overflow_total;
   logic [6:0]  columns_reg;
   logic [6:0]  rows_reg;
   logic [15:0] hcap_reg;
   logic [15:0] vcap_reg;

   ledger_request_type queued_requests[$];
   ledger_word_type    expected_words[$];
   int              fault_count = 0;
   int              words_seen = 0;
   logic            steady = 1'b0;

   // Driver and receiver bookkeeping
   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   int stall_style = 0;
   int style_left = 0;

   function automatic int clamp_dim(input logic [6:0] v);
      if (v < 2) return 2;
      if (v > GRID_MAX) return GRID_MAX;
      return int'(v);
   endfunction

   function automatic logic [15:0] excess_over(input logic [15:0] d, input logic [15:0] c);
      return (d > c) ? d - c : 16'd0;
   endfunction

   // Sweep: every overflowed edge of the grid in use gains one unit of history, saturating at the top
   task automatic bump_history(input int cols, input int rows);
      logic [11:0] slot;
      for (int x = 0; x < cols; x++) begin
         for (int y = 0; y < rows; y++) begin
            slot = {6'(x), 6'(y)};
            if (x + 1 < cols && horiz_demand[slot] > hcap_reg &&
                horiz_history[slot] != 16'hFFFF)
               horiz_history[slot] = horiz_history[slot] + 16'd1;
            if (y + 1 < rows && vert_demand[slot] > vcap_reg &&
                vert_history[slot] != 16'hFFFF)
               vert_history[slot] = vert_history[slot] + 16'd1;
         end
      end
   endtask

   // Apply one accepted request to the model and queue the word it must produce
   task automatic update_ledger(input ledger_request_type r);
      int           cols, rows, dx, dy, x0, y0;
      logic         horiz;
      logic [11:0]  slot;
      logic [15:0]  cap, dem, old_ex, new_ex, diff;
      logic [32:0]  sum;
      ledger_word_type w;
      cols = clamp_dim(columns_reg);
      rows = clamp_dim(rows_reg);
      dx = (r.from_x > r.to_x) ? r.from_x - r.to_x : r.to_x - r.from_x;
      dy = (r.from_y > r.to_y) ? r.from_y - r.to_y : r.to_y - r.from_y;
      w = '0;
      if (r.mode == MODE_SWEEP) bump_history(cols, rows);
      if (!(r.from_x < cols && r.to_x < cols && r.from_y < rows && r.to_y < rows &&
            dx + dy == 1)) begin
         w.err = ERR_EDGE;
      end else begin
         horiz = (dy == 0);
         x0 = (horiz && r.to_x < r.from_x) ? r.to_x : r.from_x;
         y0 = (!horiz && r.to_y < r.from_y) ? r.to_y : r.from_y;
         slot = {6'(x0), 6'(y0)};
         cap = horiz ? hcap_reg : vcap_reg;
         dem = horiz ? horiz_demand[slot] : vert_demand[slot];
         w.err = ERR_OK;
         old_ex = excess_over(dem, cap);
         if (r.mode == MODE_ADD) begin
            if (dem == DEMAND_TOP) w.err = ERR_SAT;
            else dem = dem + 16'd1;
         end else if (r.mode == MODE_REMOVE) begin
            if (dem == 16'd0) w.err = ERR_SAT;
            else dem = dem - 16'd1;
         end
         new_ex = excess_over(dem, cap);
         // running total: saturate going up, floor at zero going down
         if (new_ex >= old_ex) begin
            sum = {1'b0, overflow_total} + 33'(new_ex - old_ex);
            overflow_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
         end else begin
            diff = old_ex - new_ex;
            overflow_total = (overflow_total > diff) ? overflow_total - diff : 32'd0;
         end
         if (horiz) horiz_demand[slot] = dem;
         else vert_demand[slot] = dem;
         w.demand   = dem;
         w.capacity = cap;
         w.history  = horiz ? horiz_history[slot] : vert_history[slot];
         w.excess   = new_ex;
      end
      w.overflow = overflow_total;
      expected_words.insert(expected_words.size(), w);
   endtask

   task automatic queue_request(input mode_type m, input int fx, input int fy,
                                input int tx, input int ty);
      queued_requests.insert(queued_requests.size(),
                             '{m, 6'(fx), 6'(fy), 6'(tx), 6'(ty)});
   endtask

   // Mostly legal edges (often in a small corner so demand piles up),
   // some crossing the grid border, the rest raw noise
   function automatic ledger_request_type pick_request(input int sweep_pct);
      ledger_request_type r;
      int cols, rows, kind, roll, a, b, span_x, span_y;
      logic [5:0] t;
      cols = clamp_dim(columns_reg);
      rows = clamp_dim(rows_reg);
      kind = $urandom_range(0, 99);
      roll = $urandom_range(0, 99);
      if (roll < sweep_pct) r.mode = MODE_SWEEP;
      else if (roll < sweep_pct + 45) r.mode = MODE_ADD;
      else if (roll < sweep_pct + 70) r.mode = MODE_REMOVE;
      else r.mode = MODE_QUERY;
      if (kind < 20) begin
         r.mode   = mode_type'($urandom_range(0, 3));
         r.from_x = 6'($urandom);
         r.from_y = 6'($urandom);
         r.to_x   = 6'($urandom);
         r.to_y   = 6'($urandom);
      end else if (kind < 32) begin
         if ($urandom_range(0, 1)) begin
            b = $urandom_range(0, rows - 1);
            r.from_x = 6'(cols - 1);
            r.to_x   = 6'(cols);
            r.from_y = 6'(b);
            r.to_y   = 6'(b);
         end else begin
            a = $urandom_range(0, cols - 1);
            r.from_x = 6'(a);
            r.to_x   = 6'(a);
            r.from_y = 6'(rows - 1);
            r.to_y   = 6'(rows);
         end
      end else begin
         span_x = ($urandom_range(0, 1) || cols < 3) ? cols : 3;
         span_y = ($urandom_range(0, 1) || rows < 3) ? rows : 3;
         if ($urandom_range(0, 1)) begin
            a = $urandom_range(0, span_x - 2);
            b = $urandom_range(0, span_y - 1);
            r.from_x = 6'(a);
            r.to_x   = 6'(a + 1);
            r.from_y = 6'(b);
            r.to_y   = 6'(b);
         end else begin
            a = $urandom_range(0, span_x - 1);
            b = $urandom_range(0, span_y - 2);
            r.from_x = 6'(a);
            r.to_x   = 6'(a);
            r.from_y = 6'(b);
            r.to_y   = 6'(b + 1);
         end
         if ($urandom_range(0, 1)) begin
            t = r.from_x; r.from_x = r.to_x; r.to_x = t;
            t = r.from_y; r.from_y = r.to_y; r.to_y = t;
         end
      end
      return r;
   endfunction

   task automatic queue_random(input int count, input int sweep_pct);
      repeat (count) queued_requests.insert(queued_requests.size(), pick_request(sweep_pct));
   endtask

   // Wait until everything queued is sent and every word has come back
   task automatic wait_idle();
      @(negedge clock);
      while (queued_requests.size() != 0 || expected_words.size() != 0 || req_valid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_COLUMNS: columns_reg = data[6:0];
         CSR_ROWS:    rows_reg = data[6:0];
         CSR_HCAP:    hcap_reg = data;
         CSR_VCAP:    vcap_reg = data;
         default:     ;
      endcase
   endtask

   task automatic set_grid(input logic [15:0] cols, input logic [15:0] rows,
                           input logic [15:0] hcap, input logic [15:0] vcap);
      write_register(CSR_COLUMNS, cols);
      write_register(CSR_ROWS, rows);
      write_register(CSR_HCAP, hcap);
      write_register(CSR_VCAP, vcap);
      @(negedge clock);
   endtask

   // Request driver: bursts with random gaps, holds a stalled word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            update_ledger(queued_requests.pop_front());
            if (burst_left != 0) burst_left--;
         end
         if (!(req_valid && req_stall)) begin
            if (burst_left == 0 && !steady) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
            if (gap_left != 0 || queued_requests.size() == 0) begin
               if (gap_left != 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid  <= 1'b1;
               req_mode   <= queued_requests[0].mode;
               req_from_x <= queued_requests[0].from_x;
               req_from_y <= queued_requests[0].from_y;
               req_to_x   <= queued_requests[0].to_x;
               req_to_y   <= queued_requests[0].to_y;
            end
         end
      end
   end

   // Response stall: one long hold-off, none while steady, otherwise a changing pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && words_seen >= 60) begin
         hold_done = 1'b1;
         hold_left = 150;
         rsp_stall <= 1'b1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(20, 80);
         end else begin
            style_left--;
         end
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ~rsp_stall;
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic report_fault(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
      fault_count++;
      if (fault_count <= 10)
         $display("word %0d: %s expected %0d got %0d", words_seen, what, want_v, got_v);
   endtask

   task automatic check_field(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) report_fault(what, want_v, got_v);
   endtask

   // Response monitor
   always @(posedge clock) begin
      ledger_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen <= words_seen + 1;
         if (expected_words.size() == 0) begin
            report_fault("unexpected word, demand", 32'd0, 32'(rsp_edge_demand));
         end else begin
            want = expected_words.pop_front();
            check_field("edge_demand", 32'(want.demand), 32'(rsp_edge_demand));
            check_field("edge_capacity", 32'(want.capacity), 32'(rsp_edge_capacity));
            check_field("edge_history", 32'(want.history), 32'(rsp_edge_history));
            check_field("edge_excess", 32'(want.excess), 32'(rsp_edge_excess));
            check_field("overflow_sum", want.overflow, rsp_overflow_sum);
            check_field("error", 32'(want.err), 32'(rsp_error));
         end
      end
   end

   initial begin
      #15_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      for (int i = 0; i < 4096; i++) begin
         horiz_demand[i]  = 16'd0;
         vert_demand[i]   = 16'd0;
         horiz_history[i] = HISTORY_RESET;
         vert_history[i]  = HISTORY_RESET;
      end
      overflow_total = 32'd0;
      columns_reg = GRID_RESET;
      rows_reg    = GRID_RESET;
      hcap_reg    = CAP_RESET;
      vcap_reg    = CAP_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset grid 64x64, capacity 1 both ways
      queue_request(MODE_QUERY, 0, 0, 1, 0);
      queue_request(MODE_REMOVE, 0, 0, 1, 0);      // remove at zero demand
      queue_request(MODE_ADD, 0, 0, 1, 0);
      queue_request(MODE_ADD, 0, 0, 1, 0);         // first overflow
      queue_request(MODE_ADD, 1, 0, 0, 0);         // same edge named backwards
      queue_request(MODE_ADD, 63, 62, 63, 63);
      queue_request(MODE_ADD, 63, 63, 63, 62);
      queue_request(MODE_QUERY, 63, 63, 63, 62);
      queue_request(MODE_ADD, 62, 63, 63, 63);
      queue_request(MODE_QUERY, 5, 5, 5, 5);       // same point
      queue_request(MODE_ADD, 0, 0, 1, 1);         // diagonal
      queue_request(MODE_REMOVE, 0, 0, 2, 0);      // two apart
      queue_request(MODE_ADD, 63, 0, 0, 0);        // no wrap around
      queue_request(MODE_QUERY, 63, 63, 63, 63);
      queue_request(MODE_SWEEP, 0, 0, 1, 0);
      queue_request(MODE_SWEEP, 10, 10, 12, 10);   // sweep still runs on a bad edge
      queue_request(MODE_QUERY, 63, 62, 63, 63);
      queue_request(MODE_REMOVE, 1, 0, 0, 0);
      queue_request(MODE_REMOVE, 0, 0, 1, 0);
      queue_request(MODE_QUERY, 0, 0, 1, 0);
      wait_idle();

      // Smallest grid (written below the minimum), zero capacity
      set_grid(16'd0, 16'd1, 16'd0, 16'd0);
      queue_random(80, 20);
      wait_idle();

      // Pile demand onto one edge, back to back with no receiver stalls
      steady = 1'b1;
      repeat (16) queue_request(MODE_ADD, 1, 0, 0, 0);
      queue_request(MODE_QUERY, 0, 0, 1, 0);
      queue_request(MODE_SWEEP, 0, 0, 1, 0);
      repeat (2) queue_request(MODE_REMOVE, 0, 0, 1, 0);
      wait_idle();
      steady = 1'b0;

      // Wide and flat grid, full horizontal capacity (upper data bits ignored)
      set_grid(16'h0FC0, 16'd2, 16'hFFFF, 16'd3);
      queue_random(80, 15);
      wait_idle();

      // Narrow and tall grid, row count clamped from above
      set_grid(16'hFF82, 16'd127, 16'd2, 16'hFFFF);
      queue_random(80, 15);
      wait_idle();

      set_grid(16'd5, 16'd7, 16'd1, 16'd0);
      queue_random(80, 25);
      wait_idle();

      // Full grid again; sweeps kept rare since each walks every edge
      set_grid(16'd65, 16'd64, 16'd0, 16'd0);
      queue_random(50, 2);
      wait_idle();

      repeat (20) @(negedge clock);
      if (fault_count == 0 && expected_words.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
